/* design/csgu_pkg.sv */
// Shared types and constants for the centred scaled Gram block.
`timescale 1ns / 1ps
package csgu_pkg;

   localparam int C_W  = 33;  // centred value, signed Q16.16
   localparam int Q_W  = 49;  // quotient magnitude, Q.16
   localparam int D_W  = 31;  // divisor
   localparam int LO_W = 25;  // low slice of quotient for the multiplier
   localparam int HI_W = Q_W - LO_W;
   localparam int P_W  = LO_W + C_W;  // partial product
   localparam int F_W  = P_W + LO_W;  // full product magnitude
   localparam int S_W  = 64;  // accumulator entry

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* design/centered_scaled_gram_upper_core.sv */
// Top level: sequencer, shared multiplier and the two stores of the Gram block.
`timescale 1ns / 1ps
// A load request runs through the bit-serial divider, then the states RDC, MLO, MHI,
// SAT and ACC for each row of the column up to and including the loaded row, through
// the one shared 25x33 multiplier and the single read and write port of the
// accumulator memory.
// A read request is answered from ST_RESP once any earlier result has been taken.
// Requests are taken only while the block is idle.
module centered_scaled_gram_upper_core
   import csgu_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // row_idx[5:0], col_idx[15:6], z_value[47:16], col_mean[79:48], col_var[110:80]
   input  logic [111:0] req_tdata,
   // req_type[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // s_value[63:0]
   output logic [63:0]  rsp_tdata
);

   localparam int CW = $clog2(MAX_ROWS);
   localparam int AW = $clog2(MAX_ROWS * MAX_ROWS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RESP, ST_DIV, ST_RDC, ST_MLO, ST_MHI, ST_SAT, ST_ACC
   } state_type;

   logic [5:0]        f_row;
   logic [9:0]        f_col;
   logic signed [31:0] f_z, f_mean;
   logic [D_W-1:0]    f_var;

   assign f_row  = req_tdata[5:0];
   assign f_col  = req_tdata[15:6];
   assign f_z    = req_tdata[47:16];
   assign f_mean = req_tdata[79:48];
   assign f_var  = req_tdata[110:80];

   state_type       state_ff, state_in;
   logic [5:0]      row_ff, row_in;
   logic [5:0]      idx_ff, idx_in;
   logic            colz_ff, colz_in;
   logic            negc_ff, negc_in;
   logic            sneg_ff, sneg_in;
   logic [Q_W-1:0]  mq_ff, mq_in;
   logic [C_W-1:0]  mc_ff, mc_in;
   logic            negp_ff, negp_in;
   logic [P_W-1:0]  plo_ff, plo_in;
   logic [P_W-1:0]  phi_ff, phi_in;
   logic [S_W-1:0]  p_ff, p_in;
   logic            rdok_ff, rdok_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [S_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic [C_W-1:0]  cent_mem [MAX_ROWS];
   logic [S_W-1:0]  acc_mem [MAX_ROWS * MAX_ROWS];
   logic [C_W-1:0]  cent_rd_ff;
   logic [S_W-1:0]  acc_rd_ff;
   logic            cent_we, cent_re, acc_we, acc_re;
   logic [CW-1:0]   cent_wa, cent_ra;
   logic [AW-1:0]   acc_ra, acc_wa;
   logic [S_W-1:0]  acc_wd;

   logic            accept, load_ok, rd_ok;
   logic [C_W-1:0]  cval;
   logic [C_W-1:0]  cmag;
   logic [D_W-1:0]  dval;
   logic [31:0]     rd_addr_w, ld_addr_w;
   div_status_type  div_stat;
   logic [Q_W-1:0]  quot;
   logic [LO_W-1:0] mul_a;
   logic [C_W-1:0]  mul_b;
   logic [P_W-1:0]  mul_p;
   logic [C_W-1:0]  cm;
   logic [F_W-1:0]  full;
   logic            ovf;
   logic [S_W:0]    sum;
   logic [S_W-1:0]  sat_sum;

   assign accept  = req_tvalid & req_tready;
   assign load_ok = (32'(f_row) < MAX_ROWS) && (32'(f_col) < MAX_COLS);
   assign rd_ok   = (32'(f_col) < MAX_ROWS) && ({4'b0000, f_row} <= f_col);
   assign cval    = {f_z[31], f_z} - {f_mean[31], f_mean};
   assign cmag    = cval[C_W-1] ? (C_W'(0) - cval) : cval;
   assign dval    = (f_var == '0) ? D_W'(1) : f_var;

   assign rd_addr_w = 32'(f_col) * 32'(MAX_ROWS) + 32'(f_row);
   assign ld_addr_w = 32'(row_ff) * 32'(MAX_ROWS) + 32'(idx_ff);

   assign cent_we = accept && (req_tuser[0] == REQ_LOAD) && load_ok;
   assign cent_wa = CW'(f_row);
   assign cent_re = (state_ff == ST_RDC);
   assign cent_ra = CW'(idx_ff);
   assign acc_re  = (accept && (req_tuser[0] == REQ_READ)) || (state_ff == ST_RDC);
   assign acc_ra  = (state_ff == ST_IDLE) ? rd_addr_w[AW-1:0] : ld_addr_w[AW-1:0];
   assign acc_we  = (state_ff == ST_ACC);
   assign acc_wa  = ld_addr_w[AW-1:0];
   assign acc_wd  = colz_ff ? p_ff : sat_sum;

   csgu_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cent_we),
      .numer  ({cmag, 16'b0}),
      .denom  (dval),
      .status (div_stat),
      .quot   (quot)
   );

   // shared multiplier
   assign cm    = cent_rd_ff;
   assign mul_a = (state_ff == ST_MHI) ? LO_W'(mq_ff[Q_W-1:LO_W]) : mq_ff[LO_W-1:0];
   assign mul_b = (state_ff == ST_MHI) ? mc_ff : (cm[C_W-1] ? (C_W'(0) - cm) : cm);
   assign mul_p = P_W'(mul_a) * P_W'(mul_b);

   assign full = {phi_ff, {LO_W{1'b0}}} + F_W'(plo_ff);
   assign ovf  = negp_ff ? ((full[F_W-1:S_W] != '0) ||
                            (full[S_W-1] && (full[S_W-2:0] != '0)))
                         : (full[F_W-1:S_W-1] != '0);

   assign sum     = {acc_rd_ff[S_W-1], acc_rd_ff} + {p_ff[S_W-1], p_ff};
   assign sat_sum = (sum[S_W] != sum[S_W-1])
                    ? (sum[S_W] ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}})
                    : sum[S_W-1:0];

   always_ff @(posedge clock) begin
      if (cent_we) cent_mem[cent_wa] <= cval;
      if (cent_re) cent_rd_ff <= cent_mem[cent_ra];
      if (acc_we) acc_mem[acc_wa] <= acc_wd;
      if (acc_re) acc_rd_ff <= acc_mem[acc_ra];
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      colz_in       = colz_ff;
      negc_in       = negc_ff;
      sneg_in       = sneg_ff;
      mq_in         = mq_ff;
      mc_in         = mc_ff;
      negp_in       = negp_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      p_in          = p_ff;
      rdok_in       = rdok_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == REQ_READ) begin
                  rdok_in  = rd_ok;
                  state_in = ST_RESP;
               end else if (load_ok) begin
                  row_in   = f_row;
                  colz_in  = (f_col == '0);
                  negc_in  = cval[C_W-1];
                  state_in = ST_DIV;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = rdok_ff ? acc_rd_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               mq_in    = quot;
               sneg_in  = negc_ff && (quot != '0);
               idx_in   = '0;
               state_in = ST_RDC;
            end
         end
         ST_RDC: state_in = ST_MLO;
         ST_MLO: begin
            plo_in   = mul_p;
            mc_in    = mul_b;
            negp_in  = sneg_ff ^ cm[C_W-1];
            state_in = ST_MHI;
         end
         ST_MHI: begin
            phi_in   = mul_p;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (ovf) begin
               p_in = negp_ff ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}};
            end else begin
               p_in = negp_ff ? (S_W'(0) - full[S_W-1:0]) : full[S_W-1:0];
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (idx_ff == row_ff) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RDC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      idx_ff       <= idx_in;
      colz_ff      <= colz_in;
      negc_ff      <= negc_in;
      sneg_ff      <= sneg_in;
      mq_ff        <= mq_in;
      mc_ff        <= mc_in;
      negp_ff      <= negp_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      p_ff         <= p_in;
      rdok_ff      <= rdok_in;
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide phase");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (idx_ff <= row_ff))
      else $error("row loop ran past the loaded row");

   a_read_to_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser[0] == REQ_READ)) |=> (state_ff == ST_RESP))
      else $error("read request not routed to response");

   a_load_next: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser[0] == REQ_LOAD)) |=>
      (state_ff == ST_DIV || state_ff == ST_IDLE))
      else $error("load request took a wrong path");

endmodule

/* design/csgu_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module csgu_div
   import csgu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [Q_W-1:0]     numer,
   input  logic [D_W-1:0]     denom,
   output div_status_type     status,
   output logic [Q_W-1:0]     quot
);

   localparam int CNT_W = $clog2(Q_W);

   logic [Q_W-1:0]   num_ff, num_in;
   logic [D_W:0]     rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     rem_sh;
   logic [D_W+1:0]   diff;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff[D_W-1:0], num_ff[Q_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      ge      = ~diff[D_W+1];
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[Q_W-2:0], ge};
         rem_in = ge ? diff[D_W:0] : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = num_ff;

endmodule

/* tb/sv/centered_scaled_gram_upper_core_test.sv */
// Testbench for centered_scaled_gram_upper_core: directed and random requests, self-checking.
`timescale 1ns / 1ps
module centered_scaled_gram_upper_core_test
   import csgu_pkg::*;
;

   localparam int ROWS = 64;
   localparam int TOTAL_REQUESTS = 1050;
   localparam int STALL_LIMIT = 20000;

   class gram_scoreboard;
      longint centred[ROWS];
      longint gram[ROWS*ROWS];
      longint pending_entries[$];
      int     mismatches;

      function longint clamp_product(longint a, longint b);
         logic signed [127:0] wa, wb, pr;
         wa = a;
         wb = b;
         pr = wa * wb;
         if (pr > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
         if (pr < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
         return pr[63:0];
      endfunction

      function longint clamp_sum(longint a, longint b);
         logic signed [64:0] sm;
         sm = {a[63], a} + {b[63], b};
         if (sm[64] != sm[63]) return sm[64] ? 64'sh8000_0000_0000_0000
                                              : 64'sh7FFF_FFFF_FFFF_FFFF;
         return sm[63:0];
      endfunction

      function void note_request(logic kind, int row, int col, logic signed [31:0] z,
                                 logic signed [31:0] mean, logic [30:0] dv);
         longint c, mc, s;
         longint unsigned q, d;
         if (kind == REQ_READ) begin
            pending_entries.push_back((col < ROWS && row <= col) ? gram[col*ROWS+row] : 0);
            return;
         end
         c = longint'(z) - longint'(mean);
         d = (dv == 0) ? 1 : dv;
         mc = (c < 0) ? -c : c;
         q = (longint'(mc) << 16) / d;
         s = (c < 0) ? -longint'(q) : longint'(q);
         centred[row] = c;
         for (int i = 0; i <= row; i++) begin
            if (col == 0) gram[row*ROWS+i] = clamp_product(s, centred[i]);
            else gram[row*ROWS+i] = clamp_sum(gram[row*ROWS+i], clamp_product(s, centred[i]));
         end
      endfunction

      function void check_result(longint got);
         longint want;
         if (pending_entries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result s_value=%0d", got);
            return;
         end
         want = pending_entries.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("s_value mismatch: expected %0d, got %0d", want, got);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;

   gram_scoreboard board = new();
   int  requests_sent = 0;
   int  phase = 0;
   int  idle_cycles = 0;
   bit  centred_seen[ROWS];
   bit  row_defined[ROWS];

   centered_scaled_gram_upper_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic offer(logic kind, int row, int col, logic [31:0] z, logic [31:0] mean,
                        logic [30:0] dv);
      int gap_pct;
      gap_pct = (phase == 0) ? 21 : (phase == 1) ? 64 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, dv, mean, z, col[9:0], row[5:0]};
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
      board.note_request(kind, row, col, z, mean, dv);
      if (kind == REQ_LOAD) begin
         centred_seen[row] = 1;
         if (col == 0) row_defined[row] = 1;
      end
      requests_sent++;
      phase = (requests_sent < 350) ? 0 : (requests_sent < 700) ? 1 : 2;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_divisor();
      case ($urandom_range(7))
         0: return 31'd0;
         1: return 31'd1;
         2: return 31'h7FFF_FFFF;
         3, 4: return 31'($urandom_range(1, 32'h0004_0000));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic bit load_allowed(int row, int col);
      for (int i = 0; i < row; i++) if (!centred_seen[i]) return 0;
      return (col == 0) || row_defined[row];
   endfunction

   task automatic random_read();
      int row, col;
      do begin
         row = $urandom_range(63);
         col = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(63);
      end while (col < ROWS && row <= col && !row_defined[col]);
      offer(REQ_READ, row, col, $urandom, $urandom, 31'($urandom));
   endtask

   initial begin
      int col, count, row;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // short directed pass
      offer(REQ_LOAD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
      offer(REQ_LOAD, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
      offer(REQ_LOAD, 2, 0, 32'h0001_0000, 32'h0000_8000, 31'h7FFF_FFFF);
      offer(REQ_LOAD, 3, 0, 32'hFFFF_0000, 32'h0000_0000, 31'h0001_0000);
      offer(REQ_LOAD, 0, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
      offer(REQ_LOAD, 1, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
      offer(REQ_LOAD, 2, 512, 32'h0000_0000, 32'h0000_0000, 31'd5);
      offer(REQ_LOAD, 3, 1, 32'h1234_5678, 32'hFEDC_BA98, 31'h0000_0003);
      offer(REQ_READ, 0, 0, 0, 0, 0);
      offer(REQ_READ, 0, 1, 0, 0, 0);
      offer(REQ_READ, 1, 1, 0, 0, 0);
      offer(REQ_READ, 2, 3, 0, 0, 0);
      offer(REQ_READ, 3, 3, 0, 0, 0);
      offer(REQ_READ, 5, 3, 0, 0, 0);
      offer(REQ_READ, 0, 64, 0, 0, 0);
      offer(REQ_READ, 63, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      while (requests_sent < TOTAL_REQUESTS) begin
         if ($urandom_range(9) < 7) begin
            col = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1023);
            count = ($urandom_range(19) == 0) ? 64 : $urandom_range(1, 8);
            for (int r = 0; r < count; r++) if (!row_defined[r]) col = 0;
            for (int r = 0; r < count; r++)
               offer(REQ_LOAD, r, col, pick_value(), pick_value(), pick_divisor());
            repeat ($urandom_range(1, 4)) random_read();
         end else if ($urandom_range(1)) begin
            random_read();
         end else begin
            do begin
               row = $urandom_range(63);
               col = $urandom_range(1) ? 0 : $urandom_range(1023);
            end while (!load_allowed(row, col));
            offer(REQ_LOAD, row, col, pick_value(), pick_value(), pick_divisor());
         end
      end
      req_tvalid <= 0;
      while (board.pending_entries.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.mismatches == 0)
         $display("centered_scaled_gram_upper_core verification clean");
      else
         $display("centered_scaled_gram_upper_core verification failed");
      $finish;
   end

   initial begin
      bit held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (phase == 2 && !held) begin
            held = 1;
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= ((phase == 0) ? 64 : (phase == 1) ? 21 : 0));
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("centered_scaled_gram_upper_core verification failed");
            $finish;
         end
      end
   end

endmodule
